### sv/mrt_pkg.sv
package mrt_pkg;

    localparam int PAGE_COUNT_DEF = 1024;
    localparam int CFG_IDX_W      = 3;
    localparam int PB_MIN         = 12;
    localparam int PB_MAX         = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_KIND,
        CFG_REGION_VALID,
        CFG_REGION_BASE,
        CFG_REGION_BYTES,
        CFG_FIRST_PAGE_OFFSET,
        CFG_PAGE_BITS
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_LOAD,
        MODE_XLATE,
        MODE_SPLIT,
        MODE_RSVD
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_DMA,
        KIND_PAGED
    } kind_t;

    typedef enum logic [1:0] {
        STS_OK,
        STS_INVALID,
        STS_RANGE,
        STS_CROSS
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SUB_BASE,
        S_SUB_LEN,
        S_CMP,
        S_OFF,
        S_PAGE,
        S_SPAN,
        S_READ,
        S_ADD,
        S_FAULT
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ptab_ctl_t;

endpackage

### sv/mrt_if.sv
interface mrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [9:0]  page_slot;
    logic [63:0] page_base;
    logic [63:0] access_address;
    logic [15:0] access_bytes;

    modport source (
        output valid, mode, page_slot, page_base, access_address, access_bytes,
        input  ready
    );
    modport sink (
        input  valid, mode, page_slot, page_base, access_address, access_bytes,
        output ready
    );
endinterface

interface mrt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] phys_address;
    logic [15:0] segment_bytes;
    logic        last;

    modport source (
        output valid, status, phys_address, segment_bytes, last,
        input  ready
    );
    modport sink (
        input  valid, status, phys_address, segment_bytes, last,
        output ready
    );
endinterface

### sv/memory_region_translation.sv
// channel  | role   | handshake          | payload
// request  | sink   | valid/ready        | mode, page_slot, page_base, access_address,
//          |        |                    | access_bytes
// result   | source | valid/ready        | status, phys_address, segment_bytes, last
// cfg      | write  | cfg_we, no stall   | cfg_addr, cfg_wdata
// load and reserved modes end on acceptance with no result; dma and unmapped kinds, an empty
// copy (no result) and single-mode not-valid end in S_DECIDE; a page-mapped access steps from
// S_SUB_BASE to S_ADD in state order, a copy repeats S_READ and S_ADD per further segment, and
// a failed bound check ends in S_FAULT; the steps follow from one 64-bit adder that does the
// region bound checks and address sums in turn, and from the single registered page table read port
// reset clears control and configuration; page table contents stay undefined
// a full result register stalls the sequencer only where it has a result to hand over
module memory_region_translation #(
    parameter int PAGE_COUNT = mrt_pkg::PAGE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mrt_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [63:0]                    cfg_wdata,
    mrt_in_if.sink                         request,
    mrt_out_if.source                      result
);
    import mrt_pkg::*;

    localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    // room for the table size and a last page up to 16 pages past the first
    localparam int LW = AW + 7;

    // configuration
    kind_t       kind_reg;
    logic        valid_reg;
    logic [63:0] base_reg;
    logic [63:0] bytes_reg;
    logic [15:0] fpo_reg;
    logic [4:0]  pbits_reg;

    // sequencer
    state_t      state_reg, state_next;
    mode_t       mode_reg;
    logic [63:0] addr_reg;
    logic [15:0] len_reg;
    logic [63:0] diff_reg;
    logic [63:0] rem_reg;
    status_t     err_reg, err_next;
    logic [AW-1:0] pidx_reg;
    logic [15:0] in_page_reg;
    logic [15:0] seg_reg;
    logic [15:0] left_reg;

    // result register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [63:0] out_pa_reg;
    logic [15:0] out_sb_reg;
    logic        out_last_reg;

    logic        accept;
    logic        out_free;
    logic        emit;
    status_t     emit_status;
    logic [63:0] emit_pa;
    logic [15:0] emit_sb;
    logic        emit_last;

    logic [63:0] add_a, add_b;
    logic        add_cin;
    logic [64:0] add_sum;
    logic        borrow;

    logic [4:0]  pb_eff;
    logic [16:0] psize;
    logic [15:0] off_mask;
    logic [51:0] pidx_full;
    logic [16:0] span;
    logic [16:0] span_pages;
    logic [LW-1:0] last_idx;
    logic [16:0] avail;
    logic [15:0] seg_bytes;

    ptab_ctl_t   ptab_ctl;
    logic [63:0] rd_data;

    assign accept   = request.valid && request.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign request.ready = (state_reg == S_IDLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_NONE;
            valid_reg <= 1'b0;
            base_reg  <= '0;
            bytes_reg <= '0;
            fpo_reg   <= '0;
            pbits_reg <= 5'(PB_MIN);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_REGION_KIND:       kind_reg  <= kind_t'(cfg_wdata[1:0]);
                CFG_REGION_VALID:      valid_reg <= cfg_wdata[0];
                CFG_REGION_BASE:       base_reg  <= cfg_wdata;
                CFG_REGION_BYTES:      bytes_reg <= cfg_wdata;
                CFG_FIRST_PAGE_OFFSET: fpo_reg   <= cfg_wdata[15:0];
                CFG_PAGE_BITS:         pbits_reg <= cfg_wdata[4:0];
                default:               ;
            endcase
        end
    end

    // page size clamped to the supported range
    always_comb
    begin
        if (pbits_reg < 5'(PB_MIN))
        begin
            pb_eff = 5'(PB_MIN);
        end
        else if (pbits_reg > 5'(PB_MAX))
        begin
            pb_eff = 5'(PB_MAX);
        end
        else
        begin
            pb_eff = pbits_reg;
        end
    end

    assign psize    = 17'd1 << pb_eff;
    assign off_mask = 16'(psize - 17'd1);

    // page index of the in-region offset held in diff_reg
    always_comb
    begin
        case (pb_eff)
            5'd12:   pidx_full = diff_reg[63:12];
            5'd13:   pidx_full = {1'b0, diff_reg[63:13]};
            5'd14:   pidx_full = {2'b0, diff_reg[63:14]};
            5'd15:   pidx_full = {3'b0, diff_reg[63:15]};
            default: pidx_full = {4'b0, diff_reg[63:16]};
        endcase
    end

    assign span       = {1'b0, in_page_reg} + {1'b0, len_reg};
    assign span_pages = (span - 17'd1) >> pb_eff;
    assign last_idx   = LW'(pidx_reg) + LW'(span_pages);
    assign avail      = psize - {1'b0, in_page_reg};
    assign seg_bytes  = (avail > {1'b0, len_reg}) ? len_reg : avail[15:0];

    // shared 64-bit adder, subtraction by inverted operand and carry in
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_SUB_BASE:
            begin
                add_a   = addr_reg;
                add_b   = ~base_reg;
                add_cin = 1'b1;
            end
            S_SUB_LEN:
            begin
                add_a   = bytes_reg;
                add_b   = ~{48'b0, len_reg};
                add_cin = 1'b1;
            end
            S_CMP:
            begin
                add_a   = rem_reg;
                add_b   = ~diff_reg;
                add_cin = 1'b1;
            end
            S_OFF:
            begin
                add_a = diff_reg;
                add_b = {48'b0, fpo_reg};
            end
            S_ADD:
            begin
                add_a = rd_data;
                add_b = {48'b0, in_page_reg};
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + 65'(add_cin);
    assign borrow  = !add_sum[64];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        emit_status = STS_OK;
        emit_pa     = '0;
        emit_sb     = '0;
        emit_last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode_t'(request.mode) == MODE_XLATE ||
                               mode_t'(request.mode) == MODE_SPLIT))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (mode_reg == MODE_SPLIT && len_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (mode_reg == MODE_XLATE && !valid_reg)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = STS_INVALID;
                        state_next  = S_IDLE;
                    end
                end
                else if (kind_reg == KIND_DMA)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_pa    = addr_reg;
                        emit_sb    = (mode_reg == MODE_SPLIT) ? len_reg : '0;
                        state_next = S_IDLE;
                    end
                end
                else if (kind_reg != KIND_PAGED)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = STS_RANGE;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SUB_BASE;
                end
            end
            S_SUB_BASE:
            begin
                // address below the region
                err_next   = STS_RANGE;
                state_next = borrow ? S_FAULT : S_SUB_LEN;
            end
            S_SUB_LEN:
            begin
                // access longer than the region
                err_next   = STS_RANGE;
                state_next = borrow ? S_FAULT : S_CMP;
            end
            S_CMP:
            begin
                // access ends past the region
                err_next   = STS_RANGE;
                state_next = borrow ? S_FAULT : S_OFF;
            end
            S_OFF:
            begin
                state_next = S_PAGE;
            end
            S_PAGE:
            begin
                err_next   = STS_RANGE;
                state_next = (pidx_full >= 52'(PAGE_COUNT)) ? S_FAULT : S_SPAN;
            end
            S_SPAN:
            begin
                if (mode_reg == MODE_XLATE)
                begin
                    err_next   = STS_CROSS;
                    state_next = (span > psize) ? S_FAULT : S_READ;
                end
                else
                begin
                    err_next   = STS_RANGE;
                    state_next = (last_idx >= LW'(PAGE_COUNT)) ? S_FAULT : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_pa   = add_sum[63:0];
                    emit_sb   = (mode_reg == MODE_SPLIT) ? seg_reg : '0;
                    emit_last = (mode_reg == MODE_XLATE) || (left_reg == '0);
                    state_next = emit_last ? S_IDLE : S_READ;
                end
            end
            S_FAULT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_reg <= mode_t'(request.mode);
                    addr_reg <= request.access_address;
                    len_reg  <= request.access_bytes;
                end
            end
            S_SUB_BASE:
            begin
                diff_reg <= add_sum[63:0];
            end
            S_SUB_LEN:
            begin
                rem_reg <= add_sum[63:0];
            end
            S_OFF:
            begin
                diff_reg <= add_sum[63:0];
            end
            S_PAGE:
            begin
                pidx_reg    <= pidx_full[AW-1:0];
                in_page_reg <= diff_reg[15:0] & off_mask;
            end
            S_READ:
            begin
                seg_reg  <= seg_bytes;
                left_reg <= len_reg - seg_bytes;
            end
            S_ADD:
            begin
                if (emit && !emit_last)
                begin
                    len_reg     <= left_reg;
                    in_page_reg <= '0;
                    pidx_reg    <= pidx_reg + AW'(1);
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_pa_reg     <= emit_pa;
            out_sb_reg     <= emit_sb;
            out_last_reg   <= emit_last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.phys_address  = out_pa_reg;
    assign result.segment_bytes = out_sb_reg;
    assign result.last          = out_last_reg;

    // page table
    assign ptab_ctl.wr_en = accept && (mode_t'(request.mode) == MODE_LOAD) &&
                            (32'(request.page_slot) < PAGE_COUNT);
    assign ptab_ctl.rd_en = (state_reg == S_READ);

    mrt_ptab #(
        .DEPTH (PAGE_COUNT),
        .AW    (AW)
    ) u_ptab (
        .clk     (clk),
        .ctl     (ptab_ctl),
        .wr_addr (AW'(request.page_slot)),
        .wr_data (request.page_base),
        .rd_addr (pidx_reg),
        .rd_data (rd_data)
    );

`ifndef SYNTH
    a_err_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_status != STS_OK |-> emit_pa == '0 && emit_sb == '0 && emit_last)
        else $error("error result carries address or length");

    a_xlate_single: assert property (@(posedge clk) disable iff (!rst_n)
        emit && mode_reg == MODE_XLATE |-> emit_last && emit_sb == '0)
        else $error("single access gave more than one result");

    a_seg_in_page: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD && emit && mode_reg == MODE_SPLIT |->
            {1'b0, seg_reg} <= psize && seg_reg != '0)
        else $error("segment length outside one page");

    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> 32'(pidx_reg) < PAGE_COUNT)
        else $error("page table read beyond its depth");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free && state_reg != S_IDLE)
        else $error("result overwrote a pending result");
`endif

endmodule

### sv/mrt_ptab.sv
module mrt_ptab #(
    parameter int DEPTH = mrt_pkg::PAGE_COUNT_DEF,
    parameter int AW    = 10
) (
    input  logic              clk,
    input  mrt_pkg::ptab_ctl_t ctl,
    input  logic [AW-1:0]     wr_addr,
    input  logic [63:0]       wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [63:0]       rd_data
);
    import mrt_pkg::*;

    logic [63:0] entry_reg [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= entry_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
